// ===== design/tekd_pkg.sv =====
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types and constants for the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

    // longest CSI run, counting the introducer, before it is dropped
    localparam int MAX_SEQUENCE = 16;
    localparam int SEQ_W        = $clog2(MAX_SEQUENCE);

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd80;
    localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SS3     = 8'h4F;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_H       = 8'h48;

    localparam logic [3:0] NUM_MAX    = 4'd15;

    typedef enum logic [0:0] {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2,
        PH_SS3  = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        K_CHAR  = 4'd0,
        K_NONE  = 4'd1,
        K_UP    = 4'd2,
        K_DOWN  = 4'd3,
        K_LEFT  = 4'd4,
        K_RIGHT = 4'd5,
        K_DEL   = 4'd6,
        K_HOME  = 4'd7,
        K_END   = 4'd8
    } key_kind_t;

    // up to two results decoded from one input word
    typedef struct packed {
        key_kind_t  kind0;
        logic [7:0] code0;
        logic       two;
        key_kind_t  kind1;
        logic [7:0] code1;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== design/tekd_front.sv =====
// ----------------------------------------------------------------------------
// tekd_front
// Decoder state machine: takes one word a cycle unless the queue is full, and forms its result bundle.
// ----------------------------------------------------------------------------
module tekd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [7:0]          s_data_byte,
    input  tekd_pkg::queue_status_t q_status,
    output logic                push,
    output tekd_pkg::bundle_t   push_data
);

    tekd_pkg::phase_t           phase_reg, phase_next;
    logic [15:0]                wait_reg, wait_next;
    logic [tekd_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic                       digits_reg, digits_next;
    logic [3:0]                 num_reg, num_next;
    logic [15:0]                timeout_reg;

    logic                       accept;
    logic [1:0]                 n_res;
    logic [15:0]                wait_inc;
    logic [7:0]                 num_prod;
    logic [tekd_pkg::SEQ_W-1:0] seq_inc;
    tekd_pkg::key_kind_t        k_lone, k_num, k_ss3;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tekd_pkg::PH_IDLE;
            wait_reg    <= '0;
            seq_reg     <= '0;
            digits_reg  <= 1'b1;
            num_reg     <= '0;
            timeout_reg <= tekd_pkg::TIMEOUT_RESET;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg  <= phase_next;
                wait_reg   <= wait_next;
                seq_reg    <= seq_next;
                digits_reg <= digits_next;
                num_reg    <= num_next;
            end
        end
    end

    always_comb begin
        unique case (s_data_byte)
            tekd_pkg::CH_A: k_lone = tekd_pkg::K_UP;
            tekd_pkg::CH_B: k_lone = tekd_pkg::K_DOWN;
            tekd_pkg::CH_C: k_lone = tekd_pkg::K_RIGHT;
            tekd_pkg::CH_D: k_lone = tekd_pkg::K_LEFT;
            tekd_pkg::CH_H: k_lone = tekd_pkg::K_HOME;
            tekd_pkg::CH_F: k_lone = tekd_pkg::K_END;
            default:        k_lone = tekd_pkg::K_NONE;
        endcase
        unique case (num_reg)
            4'd1, 4'd7: k_num = tekd_pkg::K_HOME;
            4'd3:       k_num = tekd_pkg::K_DEL;
            4'd4, 4'd8: k_num = tekd_pkg::K_END;
            default:    k_num = tekd_pkg::K_NONE;
        endcase
        unique case (s_data_byte)
            tekd_pkg::CH_H: k_ss3 = tekd_pkg::K_HOME;
            tekd_pkg::CH_F: k_ss3 = tekd_pkg::K_END;
            default:        k_ss3 = tekd_pkg::K_NONE;
        endcase
    end

    assign wait_inc = (wait_reg < tekd_pkg::WAIT_MAX) ? wait_reg + 16'd1 : wait_reg;
    // digits are 0x30..0x39, so the low nibble is the digit value
    assign num_prod = 8'({4'd0, num_reg} * 8'd10) + {4'd0, s_data_byte[3:0]};
    assign seq_inc  = seq_reg + tekd_pkg::SEQ_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        seq_next    = seq_reg;
        digits_next = digits_reg;
        num_next    = num_reg;
        n_res       = 2'd0;
        push_data   = '{kind0: tekd_pkg::K_NONE, code0: '0, two: 1'b0,
                        kind1: tekd_pkg::K_NONE, code1: '0};

        if (s_action == tekd_pkg::ACT_TICK) begin
            if (phase_reg != tekd_pkg::PH_IDLE) begin
                wait_next = wait_inc;
                if (wait_inc >= timeout_reg) begin
                    phase_next  = tekd_pkg::PH_IDLE;
                    wait_next   = '0;
                    seq_next    = '0;
                    digits_next = 1'b1;
                    num_next    = '0;
                    n_res       = 2'd1;
                    if (phase_reg == tekd_pkg::PH_ESC) begin
                        push_data.kind0 = tekd_pkg::K_CHAR;
                        push_data.code0 = tekd_pkg::CH_ESC;
                    end
                end
            end
        end else begin
            unique case (phase_reg)
                tekd_pkg::PH_IDLE: begin
                    if (s_data_byte == tekd_pkg::CH_ESC) begin
                        phase_next = tekd_pkg::PH_ESC;
                    end else begin
                        n_res = 2'd1;
                        if (s_data_byte != tekd_pkg::CH_NUL) begin
                            push_data.kind0 = tekd_pkg::K_CHAR;
                            push_data.code0 = s_data_byte;
                        end
                    end
                end
                tekd_pkg::PH_ESC: begin
                    wait_next = '0;
                    if (s_data_byte == tekd_pkg::CH_LBRACKET) begin
                        phase_next = tekd_pkg::PH_CSI;
                    end else if (s_data_byte == tekd_pkg::CH_SS3) begin
                        phase_next = tekd_pkg::PH_SS3;
                    end else begin
                        // ESC goes out, then the byte is decoded afresh
                        push_data.kind0 = tekd_pkg::K_CHAR;
                        push_data.code0 = tekd_pkg::CH_ESC;
                        if (s_data_byte == tekd_pkg::CH_ESC) begin
                            n_res      = 2'd1;
                            phase_next = tekd_pkg::PH_ESC;
                        end else begin
                            n_res         = 2'd2;
                            push_data.two = 1'b1;
                            phase_next    = tekd_pkg::PH_IDLE;
                            if (s_data_byte != tekd_pkg::CH_NUL) begin
                                push_data.kind1 = tekd_pkg::K_CHAR;
                                push_data.code1 = s_data_byte;
                            end
                        end
                    end
                end
                tekd_pkg::PH_CSI: begin
                    if (s_data_byte >= tekd_pkg::CH_AT && s_data_byte <= tekd_pkg::CH_TILDE) begin
                        n_res       = 2'd1;
                        phase_next  = tekd_pkg::PH_IDLE;
                        wait_next   = '0;
                        seq_next    = '0;
                        digits_next = 1'b1;
                        num_next    = '0;
                        if (seq_reg == '0) begin
                            push_data.kind0 = k_lone;
                        end else if (s_data_byte == tekd_pkg::CH_TILDE && digits_reg) begin
                            push_data.kind0 = k_num;
                        end
                    end else begin
                        if (s_data_byte >= tekd_pkg::CH_ZERO && s_data_byte <= tekd_pkg::CH_NINE) begin
                            num_next = (num_prod > 8'(tekd_pkg::NUM_MAX)) ?
                                       tekd_pkg::NUM_MAX : num_prod[3:0];
                        end else begin
                            digits_next = 1'b0;
                        end
                        seq_next  = seq_inc;
                        wait_next = '0;
                        if (seq_inc >= tekd_pkg::SEQ_W'(tekd_pkg::MAX_SEQUENCE - 1)) begin
                            // overlong: give up with none
                            n_res       = 2'd1;
                            phase_next  = tekd_pkg::PH_IDLE;
                            seq_next    = '0;
                            digits_next = 1'b1;
                            num_next    = '0;
                        end
                    end
                end
                tekd_pkg::PH_SS3: begin
                    n_res           = 2'd1;
                    phase_next      = tekd_pkg::PH_IDLE;
                    wait_next       = '0;
                    push_data.kind0 = k_ss3;
                end
                default: begin
                    phase_next = tekd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign push = accept && (n_res != 2'd0);

endmodule

// ===== design/tekd_queue.sv =====
// ----------------------------------------------------------------------------
// tekd_queue
// Short register queue of result bundles between decoder and output stage.
// ----------------------------------------------------------------------------
module tekd_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tekd_pkg::bundle_t       push_data,
    input  logic                    pop,
    output tekd_pkg::bundle_t       head,
    output tekd_pkg::queue_status_t status
);

    tekd_pkg::bundle_t           mem_reg [tekd_pkg::QUEUE_DEPTH];
    logic [tekd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tekd_pkg::QCNT_W-1:0] count_reg;
    logic                        do_push, do_pop;

    assign status.full  = (count_reg == tekd_pkg::QCNT_W'(tekd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    function automatic logic [tekd_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tekd_pkg::QPTR_W-1:0] p
    );
        if (p == tekd_pkg::QPTR_W'(tekd_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + tekd_pkg::QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + tekd_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - tekd_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ===== design/tekd_back.sv =====
// ----------------------------------------------------------------------------
// tekd_back
// Output stage: hands out the one or two results of the head bundle in turn.
// ----------------------------------------------------------------------------
module tekd_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tekd_pkg::bundle_t       head,
    input  tekd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [3:0]              m_key_kind,
    output logic [7:0]              m_char_code,
    output logic                    m_last
);

    logic sel_reg, sel_next;
    logic taken;

    assign m_valid     = !q_status.empty;
    assign taken       = m_valid && m_ready;
    assign m_last      = sel_reg || !head.two;
    assign m_key_kind  = sel_reg ? head.kind1 : head.kind0;
    assign m_char_code = sel_reg ? head.code1 : head.code0;
    assign pop         = taken && m_last;

    always_comb begin
        sel_next = sel_reg;
        if (taken) begin
            sel_next = !m_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

endmodule

// ===== design/terminal_escape_key_decoder_top.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_top
// Decodes terminal bytes and ticks into keys: characters, arrows, home, end,
// delete.
// ----------------------------------------------------------------------------
// Takes one input word (byte or tick) every cycle while s_ready is high; the
// decoder updates its state in that cycle and places the word's results in a
// two-entry queue. The output stage hands out one result per cycle while
// m_ready is high, so a word giving two results (ESC followed by an ordinary
// byte) holds the output while both go out and the queue absorbs the
// difference; s_ready drops only when the queue is full.
// cfg_wr_en/cfg_wr_data load the timeout in ticks (reset 80; 0 acts as 1).
module terminal_escape_key_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_key_kind,
    output logic [7:0]  m_char_code,
    output logic        m_last
);

    tekd_pkg::queue_status_t q_status;
    tekd_pkg::bundle_t       push_data, head;
    logic                    push, pop;

    tekd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    tekd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    tekd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_kind  (m_key_kind),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    // a non-final result is always followed straight away by the final one
    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_last))
        else $error("second result of a word missing");

    a_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_key_kind != tekd_pkg::K_CHAR) |-> (m_char_code == 8'd0))
        else $error("char code set on a non-character key");

    // a full queue must hold off the input side
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.full) |-> (!s_ready && m_valid))
        else $error("input taken while queue full");

endmodule
